// File: design/bridge_adc_serial_reader_unit_macros.svh
// Assertion macros for the bridge converter serial readout block.
// Included by the top-level RTL module, which checks its own logic; no other dependencies.
`ifndef BRIDGE_ADC_SERIAL_READER_UNIT_MACROS_SVH
`define BRIDGE_ADC_SERIAL_READER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define BAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define BAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: design/bas_pkg.sv
// Shared types and constants for the bridge converter serial readout block.
// No dependencies; imported by bas_core, the top level, the checker and the testbench.
package bas_pkg;

  // Width of the reading and of the kept sample bits.
  localparam int unsigned READ_W    = 24;
  localparam int unsigned KEEP_BITS = 24;
  localparam int unsigned CNT_W     = 5;

  // Readout phase, one-hot.
  typedef enum logic [2:0] {
    PH_WAIT  = 3'b001,
    PH_DATA  = 3'b010,
    PH_EXTRA = 3'b100
  } phase_t;

  // One result item.
  typedef struct packed {
    logic              sck;
    logic              done;
    logic [READ_W-1:0] reading;
  } bas_res_t;

endpackage

// File: design/bas_core.sv
// Readout sequencer: phase, pulse counter, shift register and result logic.
// Depends on bas_pkg; advances one serial clock phase per fire strobe.
module bas_core #(
  parameter int unsigned SAMPLE_BITS  = 24,
  parameter int unsigned EXTRA_PULSES = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic                      data_bit,
  input  logic [bas_pkg::READ_W-1:0] zero_offset,
  output bas_pkg::bas_res_t         res
);
  import bas_pkg::*;

  // The sign bit sits at the top of the kept sample.
  localparam int unsigned SIGN_POS = (SAMPLE_BITS < KEEP_BITS) ? (SAMPLE_BITS - 1)
                                                              : (KEEP_BITS - 1);
  localparam logic [READ_W-1:0] SIGN_MASK = READ_W'(1) << SIGN_POS;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [READ_W-1:0]  shift_r, shift_nxt;
  logic               lvl_r, lvl_nxt;
  logic [CNT_W:0]     cnt_inc;

  assign cnt_inc = {1'b0, cnt_r} + (CNT_W+1)'(1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    lvl_nxt   = lvl_r;
    res       = '0;
    if (phase_r == PH_WAIT) begin
      cnt_nxt   = '0;
      shift_nxt = '0;
      lvl_nxt   = 1'b0;
      if (!data_bit) begin
        phase_nxt = PH_DATA;
        lvl_nxt   = 1'b1;
      end
    end else if (lvl_r) begin
      // High half of a pulse.
      res.sck = 1'b1;
      lvl_nxt = 1'b0;
    end else begin
      // Low half of a pulse: the data pin is sampled here in the data phase.
      lvl_nxt = 1'b1;
      unique case (phase_r)
        PH_DATA: begin
          if (32'(cnt_r) < KEEP_BITS) begin
            shift_nxt = {shift_r[READ_W-2:0], data_bit};
          end
          if (cnt_inc >= (CNT_W+1)'(SAMPLE_BITS)) begin
            phase_nxt = PH_EXTRA;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        PH_EXTRA: begin
          if (cnt_inc >= (CNT_W+1)'(EXTRA_PULSES)) begin
            res.done    = 1'b1;
            res.reading = (shift_r ^ SIGN_MASK) - zero_offset;
            phase_nxt   = PH_WAIT;
            cnt_nxt     = '0;
            shift_nxt   = '0;
            lvl_nxt     = 1'b0;
          end else begin
            cnt_nxt = cnt_inc[CNT_W-1:0];
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cnt_r   <= '0;
      shift_r <= '0;
      lvl_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

// File: design/bridge_adc_serial_reader_unit.sv
// Top level of the bridge converter serial readout block.
// Depends on bas_pkg, bas_core and bridge_adc_serial_reader_unit_macros.svh.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_data_in (1)
//   out_     output     out_valid/out_stall  out_sck_out (1), out_done_res (1),
//                                            out_reading (24)
//   cfg_     input      cfg_wr_en            cfg_wr_data (24), zero offset
//
// Every accepted item produces exactly one result item, which passes through the input
// register and then the result register once the output is free. One item is accepted
// per cycle while out_stall is low; the limit is the single sequencer step between them.
// Reset (rst_n low at a clock edge) empties both registers, clears the zero
// offset and returns the sequencer to waiting for the data pin to go low.
// When out_stall holds a result, the input register keeps its item and
// in_stall rises only once both registers are full.
`include "bridge_adc_serial_reader_unit_macros.svh"

module bridge_adc_serial_reader_unit #(
  parameter int unsigned SAMPLE_BITS  = 24,
  parameter int unsigned EXTRA_PULSES = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_data_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_sck_out,
  output logic                       out_done_res,
  output logic [bas_pkg::READ_W-1:0] out_reading,
  input  logic                       cfg_wr_en,
  input  logic [bas_pkg::READ_W-1:0] cfg_wr_data
);
  import bas_pkg::*;

  // Input register stage.
  logic              s1_valid_r;
  logic              s1_data_r;
  // Result register stage.
  logic              out_valid_r;
  bas_res_t          out_res_r;
  // Configuration.
  logic [READ_W-1:0] zero_offset_r;

  logic              in_acc;
  logic              adv;
  bas_res_t          step_res;

  // The input item moves into the sequencer when the result register is empty
  // or is being emptied in this cycle.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  bas_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .EXTRA_PULSES(EXTRA_PULSES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (adv),
    .data_bit   (s1_data_r),
    .zero_offset(zero_offset_r),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // The data bit carries no reset; it is only used while s1_valid_r is set.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= '0;
    end else if (cfg_wr_en) begin
      zero_offset_r <= cfg_wr_data;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sck_out  = out_res_r.sck;
  assign out_done_res = out_res_r.done;
  assign out_reading  = out_res_r.reading;

  // A reading that is not finished is presented as zero.
  `BAS_ASSERT_NOW(a_idle_reading_zero, clk, rst_n, out_valid && !out_done_res,
                  out_reading == '0, "reading nonzero without done")
  // A finished reading is presented on a low clock tick.
  `BAS_ASSERT_NOW(a_done_sck_low, clk, rst_n, out_valid && out_done_res,
                  !out_sck_out, "done with clock high")
  // The input side only stalls when both stages are full and the output waits.
  `BAS_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall,
                  s1_valid_r && out_valid_r && out_stall, "stall without full pipe")
  // A held input item is never dropped.
  `BAS_ASSERT_NEXT(a_hold_item, clk, rst_n, s1_valid_r && !adv,
                   s1_valid_r, "input item lost")

endmodule

// File: sim/bas_readout_checker.sv
// Scoreboard for the bridge converter serial readout block: predicts each result item.
// Depends on bas_pkg; instantiated beside the block by tb_bridge_adc_serial_reader_unit.
`timescale 1ns / 1ps

module bas_readout_checker #(
  parameter int unsigned SAMPLE_BITS  = 24,
  parameter int unsigned EXTRA_PULSES = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_data_in,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_sck_out,
  input  logic                       out_done_res,
  input  logic [bas_pkg::READ_W-1:0] out_reading,
  input  logic                       cfg_wr_en,
  input  logic [bas_pkg::READ_W-1:0] cfg_wr_data,
  output int                         mismatches,
  output int                         waiting_results,
  output int                         readings_seen
);
  import bas_pkg::*;

  localparam int unsigned SIGN_POS = (SAMPLE_BITS < 24) ? SAMPLE_BITS - 1 : 23;

  // Shadow copy of the sequencer and of the tare register.
  phase_t            seq_phase;
  logic [CNT_W-1:0]  pulse_idx;
  logic [READ_W-1:0] shift_reg;
  logic              half_high;
  logic [READ_W-1:0] tare;

  bas_res_t expected_q[$];
  int       errs;
  int       readings;

  function automatic void clear_sequencer();
    seq_phase = PH_WAIT;
    pulse_idx = '0;
    shift_reg = '0;
    half_high = 1'b0;
  endfunction

  // Advances the shadow sequencer by one tick and returns the result item of that tick.
  function automatic bas_res_t next_readout(input logic d);
    bas_res_t          r;
    logic [READ_W-1:0] offset_binary;
    r = '0;
    if (seq_phase == PH_DATA || seq_phase == PH_EXTRA) begin
      if (half_high) begin
        r.sck     = 1'b1;
        half_high = 1'b0;
      end else begin
        half_high = 1'b1;
        if (seq_phase == PH_DATA) begin
          if (pulse_idx < KEEP_BITS) shift_reg = {shift_reg[READ_W-2:0], d};
          if (32'(pulse_idx) + 1 >= SAMPLE_BITS) begin
            seq_phase = PH_EXTRA;
            pulse_idx = '0;
          end else begin
            pulse_idx = pulse_idx + 1'b1;
          end
        end else if (32'(pulse_idx) + 1 >= EXTRA_PULSES) begin
          offset_binary = shift_reg ^ (READ_W'(1) << SIGN_POS);
          r.reading     = offset_binary - tare;
          r.done        = 1'b1;
          clear_sequencer();
        end else begin
          pulse_idx = pulse_idx + 1'b1;
        end
      end
    end else begin
      clear_sequencer();
      if (!d) begin
        seq_phase = PH_DATA;
        half_high = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bas_res_t want;
    if (!rst_n) begin
      clear_sequencer();
      tare = '0;
      expected_q.delete();
      errs     = 0;
      readings = 0;
    end else begin
      if (cfg_wr_en) tare = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errs++;
          $display("%0t: result item with none expected: sck %0d done %0d reading %06h",
                   $time, out_sck_out, out_done_res, out_reading);
        end else begin
          want = expected_q.pop_front();
          if (out_sck_out !== want.sck) begin
            errs++;
            $display("%0t: sck mismatch, expected %0d actual %0d", $time, want.sck, out_sck_out);
          end
          if (out_done_res !== want.done) begin
            errs++;
            $display("%0t: done mismatch, expected %0d actual %0d",
                     $time, want.done, out_done_res);
          end
          if (out_reading !== want.reading) begin
            errs++;
            $display("%0t: reading mismatch, expected %06h actual %06h",
                     $time, want.reading, out_reading);
          end
          if (want.done) readings++;
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(next_readout(in_data_in));
    end
    mismatches      <= errs;
    waiting_results <= expected_q.size();
    readings_seen   <= readings;
  end

endmodule

// File: sim/tb_bridge_adc_serial_reader_unit.sv
// Testbench top for the bridge converter serial readout block: stimulus, idling and verdict.
// Depends on bas_pkg, the block itself and bas_readout_checker for prediction and checks.
`timescale 1ns / 1ps

module tb_bridge_adc_serial_reader_unit;
  import bas_pkg::*;

  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned EXTRA_PULSES = 1;
  // A cycle with nothing accepted on either channel counts toward this limit.
  // Sender gaps and receiver stalls are drawn by pick_gap and stay well under it.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1150;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_data_in;
  logic              out_valid;
  logic              out_stall;
  logic              out_sck_out;
  logic              out_done_res;
  logic [READ_W-1:0] out_reading;
  logic              cfg_wr_en;
  logic [READ_W-1:0] cfg_wr_data;

  int mismatches;
  int waiting_results;
  int readings_seen;

  // Stimulus bookkeeping, used for the closing summary.
  int items_sent;
  int tare_writes;
  int noise_bursts;

  // Idling controls: the sender's flag is private to the stimulus process,
  // the receiver's is handed to the stall process by nonblocking assignment.
  bit in_idle;
  bit out_idle;
  int stall_left = 0;

  bridge_adc_serial_reader_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .EXTRA_PULSES(EXTRA_PULSES)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_in  (in_data_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sck_out (out_sck_out),
    .out_done_res(out_done_res),
    .out_reading (out_reading),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bas_readout_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .EXTRA_PULSES(EXTRA_PULSES)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sck_out    (out_sck_out),
    .out_done_res   (out_done_res),
    .out_reading    (out_reading),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatches     (mismatches),
    .waiting_results(waiting_results),
    .readings_seen  (readings_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Most gaps are a few cycles long; about one in five is a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall bursts start only while its idling flag is on; a started burst runs to its end.
  always @(posedge clk) begin
    int g;
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_idle && $urandom_range(0, 3) == 0) begin
      g = pick_gap();
      out_stall  <= 1'b1;
      stall_left <= g - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one tick of the data pin and returns at the edge where it is accepted.
  // Valid is only lowered when a gap is inserted, so it never drops and rises in one step.
  task automatic send_item(input logic d);
    int g;
    g = 0;
    if (in_idle && $urandom_range(0, 3) == 0) g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data_in <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Holds the sender off until every expected result item has come back.
  // The block produces one result per item, so nothing is left inside after that;
  // a few more cycles cover its two stages anyway.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting_results != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes the zero offset; only called while the block is idle.
  task automatic write_tare(input logic [READ_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tare_writes++;
  endtask

  // One complete, well-formed readout: `lead` waiting ticks with the data pin high,
  // the falling data pin that starts it, then each data pulse as a high tick (pin
  // ignored, so random) and a low tick carrying the sample bit, MSB first, and
  // finally the extra pulses, during which the pin is ignored entirely.
  task automatic send_readout(input logic [31:0] sample, input int lead);
    repeat (lead) send_item(1'b1);
    send_item(1'b0);
    for (int i = SAMPLE_BITS - 1; i >= 0; i--) begin
      send_item(1'($urandom_range(0, 1)));
      send_item(sample[i]);
    end
    repeat (2 * EXTRA_PULSES) send_item(1'($urandom_range(0, 1)));
  endtask

  // A burst of random pin levels, which may start readouts at arbitrary points,
  // followed by enough high ticks for any readout it started to run to its end.
  task automatic send_noise(input int len);
    repeat (len) send_item(1'($urandom_range(0, 1)));
    repeat (2 * (SAMPLE_BITS + EXTRA_PULSES) + 2) send_item(1'b1);
    noise_bursts++;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0080_0000;
      3:       return 32'h007F_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [READ_W-1:0] pick_tare();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return READ_W'(24'h80_0000);
      default: return READ_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    int seg;
    items_sent   = 0;
    tare_writes  = 0;
    noise_bursts = 0;
    in_idle      = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data_in  <= 1'b1;
    out_idle    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at full rate on both sides. With a zero offset the reading is
    // the plain offset-binary value, so the sign-bit inversion is seen on its own.
    write_tare('0);
    send_readout(32'h0000_0000, 2);
    send_readout(32'hFFFF_FFFF, 0);  // data pin already low on the first waiting tick
    send_readout(32'h0080_0000, 1);
    send_readout(32'h007F_FFFF, 0);
    drain();
    // Full-scale offset: the subtraction wraps modulo 2^24.
    write_tare('1);
    send_readout(32'h0000_0000, 1);
    send_readout(32'h0080_0000, 3);
    drain();
    write_tare(READ_W'(24'h80_0000));
    send_readout(32'h00A5_5A5A, 0);
    send_noise(12);

    // Random part: mostly well-formed readouts with random content, some noise.
    // Idling on each side is chosen per segment, so some stretches run at full rate.
    seg = 0;
    while (items_sent < RANDOM_ITEMS) begin
      in_idle   = ($urandom_range(0, 3) != 0);
      out_idle <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        send_noise($urandom_range(5, 40));
      end else begin
        send_readout(pick_sample(), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4));
      end
      seg++;
      // Now and then the sender stops until everything is back, and the offset changes.
      if (seg % 7 == 0) begin
        drain();
        write_tare(pick_tare());
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (waiting_results != 0);
    repeat (6) @(posedge clk);

    $display("Sent %0d pin ticks in %0d segments with %0d noise bursts; %0d readings checked.",
             items_sent, seg, noise_bursts, readings_seen);
    $display("The zero offset was written %0d times, including zero and full scale.",
             tare_writes);
    if (mismatches == 0 && waiting_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
